[rtl/matrix_keypad_debounce_scanner_assert.svh]
// ----------------------------------------------------------------------------
// Keypad scanner assertion macros
// Shared property shorthands for the keypad scanner checker.
// ----------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_DEBOUNCE_SCANNER_ASSERT_SVH
`define MATRIX_KEYPAD_DEBOUNCE_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define KDS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define KDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/kds_pkg.sv]
// ----------------------------------------------------------------------------
// Keypad scanner package
// Widths, key codes, register indexes, character tables and lane structs.
// ----------------------------------------------------------------------------
package kds_pkg;

    localparam int unsigned KDS_COUNTER_WIDTH = 16;
    localparam int unsigned CFG_WIDTH         = 16;
    localparam int unsigned CFG_INDEX_WIDTH   = 2;
    localparam int unsigned NUM_BUTTONS       = 4;
    localparam int unsigned NUM_ROWS          = 4;
    localparam int unsigned NUM_COLS          = 4;

    localparam logic [CFG_WIDTH-1:0] PRESS_THR_RESET = 16'd20;
    localparam logic [CFG_WIDTH-1:0] IDLE_THR_RESET  = 16'd10;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRESS_THR = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDLE_THR  = 2'd1;

    // Key codes
    localparam logic [4:0] KEY_NONE    = 5'd0;
    localparam logic [4:0] KEY_EVAC    = 5'd17;
    localparam logic [4:0] KEY_RESET   = 5'd18;
    localparam logic [4:0] KEY_MENU    = 5'd19;
    localparam logic [4:0] KEY_SILENCE = 5'd20;

    localparam logic [3:0] COLS_IDLE = 4'hF;

    typedef struct packed {
        logic       hit;
        logic [1:0] hit_col;
        logic       report;
    } row_status_t;

    typedef struct packed {
        logic active;
        logic stop;
    } row_ctrl_t;

    typedef struct packed {
        logic       key_event;
        logic [4:0] key_code;
        logic [7:0] key_char;
    } kds_result_t;

    // Character of a matrix key number, zero for none
    function automatic logic [7:0] matrix_char(input logic [4:0] num);
        logic [7:0] c;
        case (num)
            5'd1:    c = "C";
            5'd2:    c = "1";
            5'd3:    c = "2";
            5'd4:    c = "3";
            5'd5:    c = "U";
            5'd6:    c = "4";
            5'd7:    c = "5";
            5'd8:    c = "6";
            5'd9:    c = "D";
            5'd10:   c = "7";
            5'd11:   c = "8";
            5'd12:   c = "9";
            5'd13:   c = "L";
            5'd14:   c = "R";
            5'd15:   c = "0";
            5'd16:   c = "E";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    // Character of a discrete button, in evac, reset, menu, silence order
    function automatic logic [7:0] button_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = "V";
            2'd1:    c = "T";
            2'd2:    c = "M";
            default: c = "S";
        endcase
        return c;
    endfunction

endpackage

[rtl/kds_button_lane.sv]
// ----------------------------------------------------------------------------
// Keypad scanner button lane
// Debounce counter for one active-low discrete button.
// ----------------------------------------------------------------------------
module kds_button_lane import kds_pkg::*; #(
    parameter int unsigned COUNTER_WIDTH = KDS_COUNTER_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic                 level,
    input  logic [CFG_WIDTH-1:0] press_thr,
    output logic                 fire
);

    localparam int unsigned CMP_W = (COUNTER_WIDTH > CFG_WIDTH) ? COUNTER_WIDTH : CFG_WIDTH;

    logic [COUNTER_WIDTH-1:0] count_reg;
    logic [COUNTER_WIDTH-1:0] count_next;
    logic                     below;

    assign below = CMP_W'(count_reg) <= CMP_W'(press_thr);

    // Count low ticks, fire and clear once past the threshold
    always_comb begin
        fire       = 1'b0;
        count_next = count_reg;
        if (level) begin
            count_next = '0;
        end else if (below) begin
            count_next = (&count_reg) ? count_reg : count_reg + 1'b1;
        end else begin
            count_next = '0;
            fire       = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (step_en) begin
            count_reg <= count_next;
        end
    end

endmodule

[rtl/kds_row_lane.sv]
// ----------------------------------------------------------------------------
// Keypad scanner row lane
// Key counters, arm flag and idle counter for one matrix row.
// ----------------------------------------------------------------------------
module kds_row_lane import kds_pkg::*; #(
    parameter int unsigned COUNTER_WIDTH = KDS_COUNTER_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  row_ctrl_t            ctrl,
    input  logic [3:0]           columns,
    input  logic [CFG_WIDTH-1:0] press_thr,
    input  logic [CFG_WIDTH-1:0] idle_thr,
    output row_status_t          status
);

    localparam int unsigned CMP_W = (COUNTER_WIDTH > CFG_WIDTH) ? COUNTER_WIDTH : CFG_WIDTH;

    logic [COUNTER_WIDTH-1:0] count_reg [NUM_COLS];
    logic [COUNTER_WIDTH-1:0] count_next[NUM_COLS];
    logic                     armed_reg;
    logic                     armed_next;
    logic [COUNTER_WIDTH-1:0] idle_reg;
    logic [COUNTER_WIDTH-1:0] idle_next;
    logic                     idle_below;
    logic                     all_high;

    assign all_high   = (columns == COLS_IDLE);
    assign idle_below = CMP_W'(idle_reg) < CMP_W'(idle_thr);

    // Advance the per-key counters; a held key past threshold is a hit
    always_comb begin
        status.hit     = 1'b0;
        status.hit_col = 2'd0;
        for (int k = 0; k < NUM_COLS; k++) begin
            count_next[k] = '0;
            if (columns == (COLS_IDLE ^ (4'b0001 << k))) begin
                if (CMP_W'(count_reg[k]) <= CMP_W'(press_thr)) begin
                    count_next[k] = (&count_reg[k]) ? count_reg[k] : count_reg[k] + 1'b1;
                end else begin
                    count_next[k]  = count_reg[k];
                    status.hit     = 1'b1;
                    status.hit_col = 2'(k);
                end
            end
        end
        status.report = armed_reg && all_high && !idle_below;
    end

    // Arm on a hit, count idle ticks, drop everything when this row reports
    always_comb begin
        armed_next = armed_reg;
        idle_next  = idle_reg;
        if (ctrl.stop) begin
            armed_next = 1'b0;
            idle_next  = '0;
        end else begin
            if (status.hit) begin
                armed_next = 1'b1;
            end
            if (armed_reg && all_high && idle_below) begin
                idle_next = (&idle_reg) ? idle_reg : idle_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_COLS; k++) begin
                count_reg[k] <= '0;
            end
            armed_reg <= 1'b0;
            idle_reg  <= '0;
        end else if (step_en && ctrl.active) begin
            for (int k = 0; k < NUM_COLS; k++) begin
                count_reg[k] <= count_next[k];
            end
            armed_reg <= armed_next;
            idle_reg  <= idle_next;
        end
    end

endmodule

[rtl/kds_merge.sv]
// ----------------------------------------------------------------------------
// Keypad scanner merge stage
// Orders the lanes, tracks the held key and scan start row, builds the result.
// ----------------------------------------------------------------------------
module kds_merge import kds_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  logic [NUM_BUTTONS-1:0] button_fire,
    input  row_status_t            row_status[NUM_ROWS],
    output row_ctrl_t              row_ctrl[NUM_ROWS],
    output kds_result_t            result
);

    logic [4:0] held_reg;
    logic [4:0] held_next;
    logic [1:0] start_reg;
    logic [1:0] start_next;

    // Buttons first, then rows from the start row until one reports
    always_comb begin
        logic       running;
        logic [4:0] held_v;
        running          = 1'b1;
        held_v           = held_reg;
        start_next       = 2'd0;
        result.key_event = 1'b0;
        result.key_code  = KEY_NONE;
        result.key_char  = 8'd0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (button_fire[b]) begin
                result.key_event = 1'b1;
                result.key_code  = KEY_EVAC + 5'(b);
                result.key_char  = button_char(2'(b));
            end
        end
        for (int r = 0; r < NUM_ROWS; r++) begin
            row_ctrl[r].active = running && (2'(r) >= start_reg);
            row_ctrl[r].stop   = 1'b0;
            if (row_ctrl[r].active) begin
                if (row_status[r].hit) begin
                    held_v = {1'b0, 2'(r), row_status[r].hit_col} + 5'd1;
                end
                if (row_status[r].report) begin
                    row_ctrl[r].stop = 1'b1;
                    running          = 1'b0;
                    result.key_event = 1'b1;
                    result.key_code  = held_v;
                    result.key_char  = matrix_char(held_v);
                    held_v           = KEY_NONE;
                    start_next       = 2'(r);
                end
            end
        end
        held_next = held_v;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= KEY_NONE;
            start_reg <= 2'd0;
        end else if (step_en) begin
            held_reg  <= held_next;
            start_reg <= start_next;
        end
    end

endmodule

[rtl/matrix_keypad_debounce_scanner.sv]
// ----------------------------------------------------------------------------
// Matrix keypad debounce scanner
// Debounces four discrete buttons and scans a 4x4 key matrix, one tick per
// request.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel is one scan tick: four active-low button
//   levels and the column readings of the four matrix rows. Every request
//   yields exactly one result on the m_ channel: key_event, key_code and the
//   key's ASCII character (zero when nothing was accepted).
//   Four button lanes and four row lanes update in the same cycle; a merge
//   stage orders them and the result is registered. Throughput is one
//   request per cycle while s_ready is high (no result waiting in the skid).
//   A two-entry output stage (result register plus skid register) lets a new
//   request in while a result waits; s_ready falls only when both are full,
//   and rises again as soon as the receiver takes a result.
//   Thresholds are written through cfg_we/cfg_index/cfg_wdata; the user must
//   write them only while the block is idle; the block does not enforce it.
//   Reset restores press threshold 20, idle threshold 10, clears every counter,
//   arm flag, the held key and the scan start row, and empties the output stage.
// ----------------------------------------------------------------------------
module matrix_keypad_debounce_scanner import kds_pkg::*; #(
    parameter int unsigned COUNTER_WIDTH = KDS_COUNTER_WIDTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_evac_level,
    input  logic                       s_reset_level,
    input  logic                       s_menu_level,
    input  logic                       s_silence_level,
    input  logic [3:0]                 s_row0_columns,
    input  logic [3:0]                 s_row1_columns,
    input  logic [3:0]                 s_row2_columns,
    input  logic [3:0]                 s_row3_columns,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_key_event,
    output logic [4:0]                 m_key_code,
    output logic [7:0]                 m_key_char
);

    logic [CFG_WIDTH-1:0]   press_thr_reg;
    logic [CFG_WIDTH-1:0]   idle_thr_reg;
    logic                   accept;
    logic                   take;
    logic [NUM_BUTTONS-1:0] levels;
    logic [NUM_BUTTONS-1:0] button_fire;
    logic [3:0]             row_cols[NUM_ROWS];
    row_status_t            row_status[NUM_ROWS];
    row_ctrl_t              row_ctrl[NUM_ROWS];
    kds_result_t            result;

    kds_result_t out_reg;
    kds_result_t out_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    kds_result_t skid_reg;
    kds_result_t skid_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;

    assign levels      = {s_silence_level, s_menu_level, s_reset_level, s_evac_level};
    assign row_cols[0] = s_row0_columns;
    assign row_cols[1] = s_row1_columns;
    assign row_cols[2] = s_row2_columns;
    assign row_cols[3] = s_row3_columns;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign take    = out_valid_reg && m_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_thr_reg <= PRESS_THR_RESET;
            idle_thr_reg  <= IDLE_THR_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PRESS_THR: press_thr_reg <= cfg_wdata;
                CFG_IDLE_THR:  idle_thr_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Button lanes
    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_button
        kds_button_lane #(
            .COUNTER_WIDTH(COUNTER_WIDTH)
        ) u_button (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .step_en  (accept),
            .level    (levels[b]),
            .press_thr(press_thr_reg),
            .fire     (button_fire[b])
        );
    end

    // Matrix row lanes
    for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
        kds_row_lane #(
            .COUNTER_WIDTH(COUNTER_WIDTH)
        ) u_row (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .step_en  (accept),
            .ctrl     (row_ctrl[r]),
            .columns  (row_cols[r]),
            .press_thr(press_thr_reg),
            .idle_thr (idle_thr_reg),
            .status   (row_status[r])
        );
    end

    kds_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (accept),
        .button_fire(button_fire),
        .row_status (row_status),
        .row_ctrl   (row_ctrl),
        .result     (result)
    );

    // Output register with skid: hold a second result while the receiver stalls
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            if (take) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || take) begin
                out_next       = result;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end else if (take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_key_event = out_reg.key_event;
    assign m_key_code  = out_reg.key_code;
    assign m_key_char  = out_reg.key_char;

endmodule

[rtl/kds_checker.sv]
// ----------------------------------------------------------------------------
// Keypad scanner checker
// Port-level properties of the scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "matrix_keypad_debounce_scanner_assert.svh"

module kds_port_checker import kds_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_key_event,
    input logic [4:0] m_key_code,
    input logic [7:0] m_key_char
);

    // Output stage is empty straight after reset
    `KDS_ASSERT_IMPL(a_empty_after_reset, aclk, aresetn, $past(!aresetn), !m_valid, "result valid after reset")

    // No event means no code and no character
    `KDS_ASSERT_IMPL(a_quiet_result, aclk, aresetn, m_valid && !m_key_event, (m_key_code == KEY_NONE) && (m_key_char == 8'd0), "code or char without event")

    // Codes never go past the silence button
    `KDS_ASSERT_IMPL(a_code_range, aclk, aresetn, m_valid, m_key_code <= KEY_SILENCE, "key code out of range")

    // Requests are held back only while a result waits
    `KDS_ASSERT_IMPL(a_ready_full, aclk, aresetn, !s_ready, m_valid, "input stalled with no result waiting")

    // A stalled result stays put
    `KDS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_key_code) && $stable(m_key_char) && $stable(m_key_event), "result changed under stall")

endmodule

bind matrix_keypad_debounce_scanner kds_port_checker u_kds_checker (.*);

[dv/kds_checker.sv]
// ----------------------------------------------------------------------------
// Keypad scanner result checker
// Watches the scan-tick and result channels of the keypad scanner, keeps its
// own copy of the debounce counters, arm flags and scan position, predicts
// the result of every accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module kds_checker import kds_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_wdata,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic                       s_evac_level,
    input  logic                       s_reset_level,
    input  logic                       s_menu_level,
    input  logic                       s_silence_level,
    input  logic [3:0]                 s_row0_columns,
    input  logic [3:0]                 s_row1_columns,
    input  logic [3:0]                 s_row2_columns,
    input  logic [3:0]                 s_row3_columns,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic                       m_key_event,
    input  logic [4:0]                 m_key_code,
    input  logic [7:0]                 m_key_char,
    output int unsigned                fail_count,
    output int unsigned                pending,
    output int unsigned                reports_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CW = KDS_COUNTER_WIDTH;

    // Key legends, first character in the top byte
    localparam logic [8*16-1:0] MATRIX_GLYPHS = "C123U456D789LR0E";
    localparam logic [8*4-1:0]  BUTTON_GLYPHS = "VTMS";

    // Shadow of the thresholds and the scanner state
    logic [CFG_WIDTH-1:0] press_limit;
    logic [CFG_WIDTH-1:0] idle_limit;
    logic [CW-1:0]        button_hold   [NUM_BUTTONS];
    logic [CW-1:0]        key_hold      [NUM_ROWS*NUM_COLS];
    logic                 row_armed     [NUM_ROWS];
    logic [CW-1:0]        release_ticks [NUM_ROWS];
    logic [4:0]           latched_key;
    logic [1:0]           first_row;

    kds_result_t expected_reports [$];

    // Saturating increment
    function automatic logic [CW-1:0] bump(input logic [CW-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic void clear_state();
        int unsigned i;
        press_limit = PRESS_THR_RESET;
        idle_limit  = IDLE_THR_RESET;
        for (i = 0; i < NUM_BUTTONS; i++) button_hold[i] = '0;
        for (i = 0; i < NUM_ROWS*NUM_COLS; i++) key_hold[i] = '0;
        for (i = 0; i < NUM_ROWS; i++) begin
            row_armed[i]     = 1'b0;
            release_ticks[i] = '0;
        end
        latched_key = KEY_NONE;
        first_row   = 2'd0;
    endfunction

    // Advance the shadow state by one scan tick and return its result
    function automatic kds_result_t scan_tick(input logic [3:0] levels,
                                              input logic [15:0] cols);
        kds_result_t res;
        logic [3:0]  row_cols;
        logic [3:0]  key_mask;
        int unsigned b, r, k, idx;
        logic        halted;
        res    = '0;
        halted = 1'b0;

        // Discrete buttons: evac, reset, menu, silence; later ones win
        for (b = 0; b < NUM_BUTTONS; b++) begin
            if (levels[b]) begin
                button_hold[b] = '0;
            end else if (button_hold[b] <= press_limit) begin
                button_hold[b] = bump(button_hold[b]);
            end else begin
                button_hold[b]  = '0;
                res.key_event   = 1'b1;
                res.key_code    = KEY_EVAC + 5'(b);
                res.key_char    = BUTTON_GLYPHS[8*(3-b) +: 8];
            end
        end

        // Matrix rows from the resume row upward, stop at a reporting row
        r = first_row;
        while (r < NUM_ROWS && !halted) begin
            row_cols = cols[4*r +: 4];
            for (k = 0; k < NUM_COLS; k++) begin
                idx      = r*NUM_COLS + k;
                key_mask = COLS_IDLE ^ (4'b0001 << k);
                if (row_cols == key_mask) begin
                    if (key_hold[idx] <= press_limit) begin
                        key_hold[idx] = bump(key_hold[idx]);
                    end else begin
                        latched_key  = 5'(idx + 1);
                        row_armed[r] = 1'b1;
                    end
                end else begin
                    key_hold[idx] = '0;
                end
            end
            if (row_armed[r] && row_cols == COLS_IDLE) begin
                if (release_ticks[r] < idle_limit) begin
                    release_ticks[r] = bump(release_ticks[r]);
                end else begin
                    // the latched number may already be cleared by another row
                    res.key_event = 1'b1;
                    res.key_code  = (latched_key <= 5'd16) ? latched_key : KEY_NONE;
                    res.key_char  = (res.key_code == KEY_NONE) ? 8'd0 :
                                    MATRIX_GLYPHS[8*(16-res.key_code) +: 8];
                    row_armed[r]     = 1'b0;
                    release_ticks[r] = '0;
                    latched_key      = KEY_NONE;
                    halted           = 1'b1;
                end
            end
            if (!halted) r++;
        end
        first_row = halted ? 2'(r) : 2'd0;
        return res;
    endfunction

    function automatic int unsigned field_miss(input string name,
                                               input logic [7:0] want,
                                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    initial clear_state();

    // Track writes, predict accepted requests, compare delivered results
    always @(posedge aclk) begin : watch
        kds_result_t want;
        int unsigned misses;
        int unsigned reports;
        misses  = 0;
        reports = 0;
        if (!aresetn) begin
            clear_state();
            expected_reports.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PRESS_THR: press_limit = cfg_wdata;
                    CFG_IDLE_THR:  idle_limit  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_reports.push_back(scan_tick(
                    {s_silence_level, s_menu_level, s_reset_level, s_evac_level},
                    {s_row3_columns, s_row2_columns, s_row1_columns, s_row0_columns}));
            end
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: result with nothing expected, key_code %0d",
                             $time, m_key_code);
                    misses++;
                end else begin
                    want = expected_reports.pop_front();
                    misses += field_miss("key_event", want.key_event, m_key_event);
                    misses += field_miss("key_code", want.key_code, m_key_code);
                    misses += field_miss("key_char", want.key_char, m_key_char);
                    if (want.key_event) reports++;
                end
            end
        end
        fail_count   <= fail_count + misses;
        reports_seen <= reports_seen + reports;
        pending      <= expected_reports.size();
    end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// Keypad scanner testbench
// Resets the scanner once, then runs a directed sequence of presses, chatter
// and stale-row reports followed by randomised press/release episodes under
// several threshold settings and handshake idling patterns. The checker
// predicts and compares every result; this module drives and gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_top import kds_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]       cfg_wdata;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_evac_level;
    logic                       s_reset_level;
    logic                       s_menu_level;
    logic                       s_silence_level;
    logic [3:0]                 s_row0_columns;
    logic [3:0]                 s_row1_columns;
    logic [3:0]                 s_row2_columns;
    logic [3:0]                 s_row3_columns;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_key_event;
    logic [4:0]                 m_key_code;
    logic [7:0]                 m_key_char;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned reports_seen;

    int unsigned send_gap_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned ticks_sent     = 0;
    int unsigned settings_seen  = 1;
    int unsigned press_now      = PRESS_THR_RESET;
    int unsigned idle_now       = IDLE_THR_RESET;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    matrix_keypad_debounce_scanner i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_evac_level   (s_evac_level),
        .s_reset_level  (s_reset_level),
        .s_menu_level   (s_menu_level),
        .s_silence_level(s_silence_level),
        .s_row0_columns (s_row0_columns),
        .s_row1_columns (s_row1_columns),
        .s_row2_columns (s_row2_columns),
        .s_row3_columns (s_row3_columns),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_key_event    (m_key_event),
        .m_key_code     (m_key_code),
        .m_key_char     (m_key_char)
    );

    kds_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_evac_level   (s_evac_level),
        .s_reset_level  (s_reset_level),
        .s_menu_level   (s_menu_level),
        .s_silence_level(s_silence_level),
        .s_row0_columns (s_row0_columns),
        .s_row1_columns (s_row1_columns),
        .s_row2_columns (s_row2_columns),
        .s_row3_columns (s_row3_columns),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_key_event    (m_key_event),
        .m_key_code     (m_key_code),
        .m_key_char     (m_key_char),
        .fail_count     (fail_count),
        .pending        (pending),
        .reports_seen   (reports_seen)
    );

    // Receiver: stall at random at the configured rate
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Present one scan tick and hold it until it is taken
    task automatic send_tick(input logic [3:0] levels, input logic [15:0] cols);
        @(negedge aclk);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_evac_level    <= levels[0];
        s_reset_level   <= levels[1];
        s_menu_level    <= levels[2];
        s_silence_level <= levels[3];
        s_row0_columns  <= cols[3:0];
        s_row1_columns  <= cols[7:4];
        s_row2_columns  <= cols[11:8];
        s_row3_columns  <= cols[15:12];
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
    endtask

    // Hold off requests until every result is back, then let the block settle
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input int unsigned press, input int unsigned idle,
                             input int unsigned gap, input int unsigned stall);
        settle();
        write_reg(CFG_PRESS_THR, CFG_WIDTH'(press));
        write_reg(CFG_IDLE_THR, CFG_WIDTH'(idle));
        press_now      = press;
        idle_now       = idle;
        send_gap_pct   = gap;
        sink_stall_pct = stall;
        settings_seen++;
    endtask

    // Idle lines {columns, levels} with one key down: 0..15 matrix, 16..19 buttons
    function automatic logic [19:0] key_lines(input int unsigned which);
        logic [19:0] lines;
        lines = '1;
        if (which >= 16)
            lines[which-16] = 1'b0;
        else
            lines[4 + 4*(which/4) +: 4] = COLS_IDLE ^ (4'b0001 << (which % 4));
        return lines;
    endfunction

    // Hold a key (sometimes two), then release, with occasional chatter
    task automatic key_episode(input int unsigned hold_len, input int unsigned rel_len);
        int unsigned first_key;
        int unsigned second_key;
        logic        two_keys;
        logic [19:0] lines;
        int unsigned i;
        first_key  = $urandom_range(19);
        second_key = $urandom_range(19);
        two_keys   = ($urandom_range(99) < 20);
        for (i = 0; i < hold_len + rel_len; i++) begin
            lines = '1;
            if (i < hold_len) begin
                lines = key_lines(first_key);
                if (two_keys) lines = lines & key_lines(second_key);
            end
            if ($urandom_range(99) < 6) lines[$urandom_range(3)] ^= 1'b1;
            if ($urandom_range(99) < 6) lines[4 + 4*$urandom_range(3) +: 4] = 4'($urandom);
            send_tick(lines[3:0], lines[19:4]);
        end
    endtask

    // Mostly well-formed presses, some bounces, some pure noise
    task automatic random_ticks(input int unsigned budget);
        int unsigned start;
        int unsigned pick;
        int unsigned press_cap;
        int unsigned idle_cap;
        start     = ticks_sent;
        press_cap = (press_now > 24) ? 24 : press_now;
        idle_cap  = (idle_now > 24) ? 24 : idle_now;
        while (ticks_sent - start < budget) begin
            pick = $urandom_range(99);
            if (pick < 70)
                key_episode(press_cap + $urandom_range(4), idle_cap + $urandom_range(3));
            else if (pick < 85)
                key_episode($urandom_range(press_cap + 1, 1), $urandom_range(3));
            else
                send_tick(4'($urandom), 16'($urandom));
        end
    endtask

    initial begin : stimulus
        aresetn         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_PRESS_THR;
        cfg_wdata       = '0;
        s_valid         = 1'b0;
        s_evac_level    = 1'b1;
        s_reset_level   = 1'b1;
        s_menu_level    = 1'b1;
        s_silence_level = 1'b1;
        s_row0_columns  = COLS_IDLE;
        s_row1_columns  = COLS_IDLE;
        s_row2_columns  = COLS_IDLE;
        s_row3_columns  = COLS_IDLE;
        m_ready         = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Thresholds as they come out of reset
        random_ticks(200);

        // Directed: fastest thresholds so each case takes a few ticks
        configure(0, 0, 0, 0);
        send_tick(4'hF, 16'hFFFF);
        // all buttons at once, silence wins
        send_tick(4'h0, 16'hFFFF);
        send_tick(4'h0, 16'hFFFF);
        // keys in rows 0 and 3, row 3 latches last
        send_tick(4'hF, 16'h7FFE);
        send_tick(4'hF, 16'h7FFE);
        // row 0 reports row 3's key, scan stops there; row 3 then reports no key
        send_tick(4'hF, 16'hFFFF);
        send_tick(4'hF, 16'hFFFF);
        // row 1 key broken by all columns low, then pressed again
        send_tick(4'hF, 16'hFFDF);
        send_tick(4'hF, 16'hFF0F);
        send_tick(4'hF, 16'hFFDF);
        send_tick(4'hF, 16'hFFDF);
        // two low columns: not a key and no idle count
        send_tick(4'hF, 16'hFF3F);
        send_tick(4'hF, 16'hFFFF);
        // rows 0 and 2 armed, scan resumes at the reporting row
        send_tick(4'hF, 16'hFEFB);
        send_tick(4'hF, 16'hFEFB);
        send_tick(4'hF, 16'hFFFF);
        send_tick(4'hF, 16'hFFFF);
        send_tick(4'hF, 16'hFFFF);
        // button and matrix key together
        send_tick(4'hE, 16'hEFFF);
        send_tick(4'hE, 16'hEFFF);
        send_tick(4'hF, 16'hFFFF);
        // reset and silence low with every column low
        send_tick(4'h5, 16'h0000);
        send_tick(4'h5, 16'h0000);

        // Random phases across thresholds and idling patterns
        configure(1, 1, 0, 0);
        random_ticks(250);
        configure(2, 3, 68, 0);
        random_ticks(250);
        configure(3, 0, 0, 68);
        random_ticks(250);
        configure(0, 2, 38, 38);
        random_ticks(250);
        configure(65534, 65535, 38, 38);
        random_ticks(150);
        configure(5, 4, 68, 0);
        random_ticks(200);
        configure(0, 0, 0, 68);
        random_ticks(150);
        configure(4, 1, 0, 0);
        random_ticks(150);

        settle();
        $display("Scanned %0d ticks under %0d threshold settings, %0d key reports checked.",
                 ticks_sent, settings_seen, reports_seen);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Drop the run if it hangs
    initial begin : watchdog
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
